// ===== rtl/esc_cts_pkg.sv =====
// Shared types, constants and helpers of the ESC commutation and throttle supervisor.
`default_nettype none

package esc_cts_pkg;

   // Field widths
   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned DELAY_W  = 19;
   localparam int unsigned CMP_W    = 10;
   localparam int unsigned PULSE_W  = 14;
   localparam int unsigned REM_W    = 20;
   localparam int unsigned LOSS_W   = 10;
   localparam int unsigned BEEP_W   = 16;
   localparam int unsigned SPEED_W  = 8;
   localparam int unsigned BAD_W    = 8;
   localparam int unsigned STATE_W  = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 48;

   // Length of one timer period in microseconds
   localparam int unsigned TIMER_PERIOD = 999;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK         = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCHED_DETECT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SCHED_NEXT   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DETECT_MATCH = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_NEXT_MATCH   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_START_DONE   = 3'd5;

   // Register indexes of the CSR write channel
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_LOSS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAD_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_ZERO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_TICK  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_DELAY = 3'd7;

   // Reported motor state codes
   localparam logic [STATE_W-1:0] STATE_STANDBY = 3'd0;
   localparam logic [STATE_W-1:0] STATE_START   = 3'd1;
   localparam logic [STATE_W-1:0] STATE_RUNNING = 3'd2;
   localparam logic [STATE_W-1:0] STATE_STOP    = 3'd3;
   localparam logic [STATE_W-1:0] STATE_ERROR   = 3'd4;

   typedef enum logic [4:0] {
      MODE_STANDBY = 5'b00001,
      MODE_START   = 5'b00010,
      MODE_RUNNING = 5'b00100,
      MODE_STOP    = 5'b01000,
      MODE_ERROR   = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [LOSS_W-1:0]  signal_loss_ticks;
      logic [BEEP_W-1:0]  beep_period;
      logic [BAD_W-1:0]   bad_step_limit;
      logic [PULSE_W-1:0] throttle_zero;
      logic [CMP_W-1:0]   duty_max;
      logic [CMP_W-1:0]   duty_min;
      logic [SPEED_W-1:0] speed_tick_period;
      logic [CMP_W-1:0]   short_delay;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [DELAY_W-1:0] delay_us;
      logic [CMP_W-1:0]   timer_now;
      logic               pulse_seen;
      logic [PULSE_W-1:0] pulse_width;
   } req_item_type;

   // What the current item asks of one commutation channel
   typedef struct packed {
      logic schedule;
      logic match;
      logic tick;
   } chan_ctrl_type;

   typedef struct packed {
      logic             fire;
      logic             armed;
      logic [CMP_W-1:0] compare;
   } chan_status_type;

   typedef struct packed {
      logic [CMP_W-1:0]   duty;
      logic               duty_write;
      logic [STATE_W-1:0] motor_state;
      logic               beep;
      logic               speed_tick;
      logic               commutation_error;
   } sup_status_type;

   function automatic logic [STATE_W-1:0] mode_code(input mode_type mode);
      logic [STATE_W-1:0] code;
      unique case (mode)
         MODE_STANDBY: code = STATE_STANDBY;
         MODE_START:   code = STATE_START;
         MODE_RUNNING: code = STATE_RUNNING;
         MODE_STOP:    code = STATE_STOP;
         MODE_ERROR:   code = STATE_ERROR;
         default:      code = STATE_STANDBY;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/esc_cts_channel.sv =====
// One delayed-commutation channel: scheduling, compare arming, held countdown and match.
`default_nettype none

module esc_cts_channel (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire esc_cts_pkg::chan_ctrl_type            ctrl,
   input  wire logic [esc_cts_pkg::DELAY_W-1:0]       delay_us,
   input  wire logic [esc_cts_pkg::CMP_W-1:0]         timer_now,
   input  wire logic [esc_cts_pkg::CMP_W-1:0]         short_delay,
   output esc_cts_pkg::chan_status_type               status
);

   localparam int unsigned REM_W = esc_cts_pkg::REM_W;
   localparam int unsigned CMP_W = esc_cts_pkg::CMP_W;

   logic             pending_ff, pending_in;
   logic [REM_W-1:0] remaining_ff, remaining_in;
   logic             enable_ff, enable_in;
   logic [CMP_W-1:0] compare_ff, compare_in;
   logic             fire;

   logic [REM_W-1:0] end_sum;
   logic [REM_W:0]   held_limit;
   logic [REM_W-1:0] held_left;
   logic [REM_W-1:0] period;

   assign period     = REM_W'(esc_cts_pkg::TIMER_PERIOD);
   assign end_sum    = REM_W'(delay_us) + REM_W'(timer_now);
   assign held_limit = (REM_W+1)'(esc_cts_pkg::TIMER_PERIOD) + (REM_W+1)'(short_delay);
   assign held_left  = remaining_ff - period;

   always_comb begin
      pending_in   = pending_ff;
      remaining_in = remaining_ff;
      enable_in    = enable_ff;
      compare_in   = compare_ff;
      fire         = 1'b0;
      priority if (ctrl.schedule) begin
         if (delay_us <= esc_cts_pkg::DELAY_W'(short_delay)) begin
            // Short enough to commutate straight away.
            enable_in = 1'b0;
            fire      = 1'b1;
         end else if (end_sum <= period) begin
            compare_in = end_sum[CMP_W-1:0];
            enable_in  = 1'b1;
         end else begin
            enable_in    = 1'b0;
            remaining_in = end_sum;
            pending_in   = 1'b1;
         end
      end else if (ctrl.match) begin
         if (enable_ff) begin
            enable_in  = 1'b0;
            pending_in = 1'b0;
            fire       = 1'b1;
         end
      end else if (ctrl.tick && pending_ff) begin
         if ({1'b0, remaining_ff} <= held_limit) begin
            remaining_in = (remaining_ff > period) ? held_left : '0;
            enable_in    = 1'b0;
            pending_in   = 1'b0;
            fire         = 1'b1;
         end else begin
            // Count one period off; arm the compare once the rest fits in a period.
            remaining_in = held_left;
            if (held_left <= period) begin
               compare_in = held_left[CMP_W-1:0];
               enable_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         remaining_ff <= '0;
         enable_ff    <= 1'b0;
         compare_ff   <= '0;
      end else if (advance) begin
         pending_ff   <= pending_in;
         remaining_ff <= remaining_in;
         enable_ff    <= enable_in;
         compare_ff   <= compare_in;
      end
   end

   assign status.fire    = fire;
   assign status.armed   = enable_in;
   assign status.compare = compare_in;

endmodule

`default_nettype wire

// ===== rtl/esc_cts_supervisor.sv =====
// Throttle watch, motor mode sequencing, duty clamp, beep and speed pacing, bad-step check.
`default_nettype none

module esc_cts_supervisor (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire logic [esc_cts_pkg::FUNC_W-1:0]        func,
   input  wire logic                                  pulse_seen,
   input  wire logic [esc_cts_pkg::PULSE_W-1:0]       pulse_width,
   input  wire logic                                  next_fire,
   input  wire esc_cts_pkg::cfg_type                  cfg,
   output esc_cts_pkg::sup_status_type                status
);

   localparam int unsigned LOSS_W  = esc_cts_pkg::LOSS_W;
   localparam int unsigned BEEP_W  = esc_cts_pkg::BEEP_W;
   localparam int unsigned SPEED_W = esc_cts_pkg::SPEED_W;
   localparam int unsigned BAD_W   = esc_cts_pkg::BAD_W;
   localparam int unsigned CMP_W   = esc_cts_pkg::CMP_W;
   localparam int unsigned PULSE_W = esc_cts_pkg::PULSE_W;

   esc_cts_pkg::mode_type mode_ff, mode_in;
   logic                  no_signal_ff, no_signal_in;
   logic [LOSS_W-1:0]     loss_ff, loss_in;
   logic [BEEP_W-1:0]     beep_cnt_ff, beep_cnt_in;
   logic [SPEED_W-1:0]    speed_cnt_ff, speed_cnt_in;
   logic [BAD_W-1:0]      bad_ff, bad_in;
   logic [CMP_W-1:0]      duty_ff, duty_in;
   logic [PULSE_W-1:0]    thr_ff, thr_in;

   logic                  duty_write, beep, speed_tick, cerr;
   logic [PULSE_W-1:0]    thr_over;
   logic                  thr_up;

   assign thr_up   = (thr_in >= cfg.throttle_zero);
   assign thr_over = thr_in - cfg.throttle_zero;

   always_comb begin
      mode_in      = mode_ff;
      no_signal_in = no_signal_ff;
      loss_in      = loss_ff;
      beep_cnt_in  = beep_cnt_ff;
      speed_cnt_in = speed_cnt_ff;
      duty_in      = duty_ff;
      thr_in       = thr_ff;
      duty_write   = 1'b0;
      beep         = 1'b0;
      speed_tick   = 1'b0;
      cerr         = 1'b0;

      // A next-step commutation counts as a bad step, saturating.
      bad_in = (next_fire && (bad_ff != '1)) ? bad_ff + 1'b1 : bad_ff;

      if (func == esc_cts_pkg::FUNC_START_DONE) begin
         if (mode_ff == esc_cts_pkg::MODE_START) begin
            mode_in = esc_cts_pkg::MODE_RUNNING;
         end
      end else if (func == esc_cts_pkg::FUNC_TICK) begin
         if (!pulse_seen) begin
            if (!no_signal_ff && (loss_ff != '1)) begin
               loss_in = loss_ff + 1'b1;
            end
            if (loss_in >= cfg.signal_loss_ticks) begin
               no_signal_in = 1'b1;
            end
         end else begin
            no_signal_in = 1'b0;
            loss_in      = '0;
            thr_in       = pulse_width;
         end

         if (!no_signal_in) begin
            if (mode_ff == esc_cts_pkg::MODE_RUNNING) begin
               if (thr_up) begin
                  // Upper clamp first, then the lower one.
                  if (thr_over >= PULSE_W'(cfg.duty_max)) begin
                     duty_in = cfg.duty_max;
                  end else if (thr_over <= PULSE_W'(cfg.duty_min)) begin
                     duty_in = cfg.duty_min;
                  end else begin
                     duty_in = thr_over[CMP_W-1:0];
                  end
               end else begin
                  mode_in    = esc_cts_pkg::MODE_STOP;
                  duty_in    = '0;
                  duty_write = 1'b1;
               end
            end else if (mode_ff == esc_cts_pkg::MODE_STANDBY) begin
               if (thr_up) begin
                  mode_in = esc_cts_pkg::MODE_START;
               end
            end else if ((mode_ff == esc_cts_pkg::MODE_STOP) ||
                         (mode_ff == esc_cts_pkg::MODE_ERROR)) begin
               if (!thr_up) begin
                  mode_in = esc_cts_pkg::MODE_STANDBY;
               end
               beep_cnt_in = beep_cnt_ff + 1'b1;
               if (beep_cnt_in == cfg.beep_period) begin
                  beep        = 1'b1;
                  beep_cnt_in = '0;
               end
            end
         end else begin
            if (mode_ff != esc_cts_pkg::MODE_STOP) begin
               mode_in    = esc_cts_pkg::MODE_STOP;
               duty_in    = '0;
               duty_write = 1'b1;
            end else begin
               beep_cnt_in = beep_cnt_ff + 1'b1;
            end
            if (beep_cnt_in == cfg.beep_period) begin
               beep        = 1'b1;
               beep_cnt_in = '0;
            end
         end

         if ((mode_in == esc_cts_pkg::MODE_RUNNING) || (mode_in == esc_cts_pkg::MODE_START)) begin
            speed_cnt_in = speed_cnt_ff + 1'b1;
            if (speed_cnt_in == cfg.speed_tick_period) begin
               speed_tick   = 1'b1;
               speed_cnt_in = '0;
            end
            if (bad_in >= cfg.bad_step_limit) begin
               mode_in    = esc_cts_pkg::MODE_ERROR;
               cerr       = 1'b1;
               duty_in    = '0;
               duty_write = 1'b1;
               bad_in     = '0;
            end
         end
         if ((mode_in == esc_cts_pkg::MODE_RUNNING) || (mode_in == esc_cts_pkg::MODE_START)) begin
            duty_write = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= esc_cts_pkg::MODE_STANDBY;
         no_signal_ff <= 1'b1;
         loss_ff      <= '0;
         beep_cnt_ff  <= '0;
         speed_cnt_ff <= '0;
         bad_ff       <= '0;
         duty_ff      <= '0;
         thr_ff       <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         no_signal_ff <= no_signal_in;
         loss_ff      <= loss_in;
         beep_cnt_ff  <= beep_cnt_in;
         speed_cnt_ff <= speed_cnt_in;
         bad_ff       <= bad_in;
         duty_ff      <= duty_in;
         thr_ff       <= thr_in;
      end
   end

   assign status.duty              = duty_in;
   assign status.duty_write        = duty_write;
   assign status.motor_state       = esc_cts_pkg::mode_code(mode_in);
   assign status.beep              = beep;
   assign status.speed_tick        = speed_tick;
   assign status.commutation_error = cerr;

endmodule

`default_nettype wire

// ===== rtl/esc_commutation_and_throttle_supervisor.sv =====
// Top level of the ESC commutation and throttle supervisor: stream ports, CSRs, stage registers.
`default_nettype none

// A request transfer appears as a response through the request register, then the response
// register, or later while the response side stalls. Throughput: one request per cycle
// while rsp_tready stays high; every request yields exactly one response.
// The request and response registers decouple the two sides, so a new request is taken while
// a finished response still waits. Synchronous active-high reset returns every CSR to its
// default, puts the motor in standby with the signal marked lost and clears both channels.
module esc_commutation_and_throttle_supervisor (
   input  wire logic                                    clock,
   input  wire logic                                    reset,

   // Request stream
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // tdata, lowest bit first: delay_us[18:0], timer_now[28:19], pulse_seen[29],
   // pulse_width[43:30], zero fill[47:44]
   input  wire logic [esc_cts_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: func[2:0]
   input  wire logic [esc_cts_pkg::FUNC_W-1:0]          req_tuser,

   // Response stream
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // tdata, lowest bit first: fire_detect[0], fire_next[1], detect_armed[2], next_armed[3],
   // detect_compare[13:4], next_compare[23:14], duty[33:24], duty_write[34],
   // motor_state[37:35], beep[38], speed_tick[39], commutation_error[40], zero fill[47:41]
   output logic [esc_cts_pkg::RSP_DATA_W-1:0]           rsp_tdata,

   // CSR write channel
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [esc_cts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [esc_cts_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int unsigned RSP_DATA_W = esc_cts_pkg::RSP_DATA_W;

   // Configuration registers. Writes are always accepted; they are expected only when idle.
   esc_cts_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signal_loss_ticks <= esc_cts_pkg::LOSS_W'(500);
         cfg_ff.beep_period       <= esc_cts_pkg::BEEP_W'(4000);
         cfg_ff.bad_step_limit    <= esc_cts_pkg::BAD_W'(50);
         cfg_ff.throttle_zero     <= esc_cts_pkg::PULSE_W'(1000);
         cfg_ff.duty_max          <= esc_cts_pkg::CMP_W'(999);
         cfg_ff.duty_min          <= esc_cts_pkg::CMP_W'(5);
         cfg_ff.speed_tick_period <= esc_cts_pkg::SPEED_W'(10);
         cfg_ff.short_delay       <= esc_cts_pkg::CMP_W'(20);
      end else if (csr_valid) begin
         unique case (csr_index)
            esc_cts_pkg::CSR_SIGNAL_LOSS:
               cfg_ff.signal_loss_ticks <= csr_data[esc_cts_pkg::LOSS_W-1:0];
            esc_cts_pkg::CSR_BEEP_PERIOD:
               cfg_ff.beep_period <= csr_data[esc_cts_pkg::BEEP_W-1:0];
            esc_cts_pkg::CSR_BAD_LIMIT:
               cfg_ff.bad_step_limit <= csr_data[esc_cts_pkg::BAD_W-1:0];
            esc_cts_pkg::CSR_THR_ZERO:
               cfg_ff.throttle_zero <= csr_data[esc_cts_pkg::PULSE_W-1:0];
            esc_cts_pkg::CSR_DUTY_MAX:
               cfg_ff.duty_max <= csr_data[esc_cts_pkg::CMP_W-1:0];
            esc_cts_pkg::CSR_DUTY_MIN:
               cfg_ff.duty_min <= csr_data[esc_cts_pkg::CMP_W-1:0];
            esc_cts_pkg::CSR_SPEED_TICK:
               cfg_ff.speed_tick_period <= csr_data[esc_cts_pkg::SPEED_W-1:0];
            esc_cts_pkg::CSR_SHORT_DELAY:
               cfg_ff.short_delay <= csr_data[esc_cts_pkg::CMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Request register. The held request is processed once the response register can take
   // its result; that same edge updates all supervisor and channel state.
   logic                      in_valid_ff;
   esc_cts_pkg::req_item_type in_item_ff;
   logic                      out_valid_ff;
   logic [RSP_DATA_W-1:0]     out_data_ff, out_data_in;
   logic                      advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.func        <= req_tuser;
         in_item_ff.delay_us    <= req_tdata[18:0];
         in_item_ff.timer_now   <= req_tdata[28:19];
         in_item_ff.pulse_seen  <= req_tdata[29];
         in_item_ff.pulse_width <= req_tdata[43:30];
      end
   end

   // Decode which channel each request concerns.
   esc_cts_pkg::chan_ctrl_type   det_ctrl, nxt_ctrl;
   esc_cts_pkg::chan_status_type det_status, nxt_status;
   esc_cts_pkg::sup_status_type  sup_status;
   logic                         is_tick;

   assign is_tick           = (in_item_ff.func == esc_cts_pkg::FUNC_TICK);
   assign det_ctrl.schedule = (in_item_ff.func == esc_cts_pkg::FUNC_SCHED_DETECT);
   assign det_ctrl.match    = (in_item_ff.func == esc_cts_pkg::FUNC_DETECT_MATCH);
   assign det_ctrl.tick     = is_tick;
   assign nxt_ctrl.schedule = (in_item_ff.func == esc_cts_pkg::FUNC_SCHED_NEXT);
   assign nxt_ctrl.match    = (in_item_ff.func == esc_cts_pkg::FUNC_NEXT_MATCH);
   assign nxt_ctrl.tick     = is_tick;

   esc_cts_channel u_detect (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .ctrl        (det_ctrl),
      .delay_us    (in_item_ff.delay_us),
      .timer_now   (in_item_ff.timer_now),
      .short_delay (cfg_ff.short_delay),
      .status      (det_status)
   );

   esc_cts_channel u_next (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .ctrl        (nxt_ctrl),
      .delay_us    (in_item_ff.delay_us),
      .timer_now   (in_item_ff.timer_now),
      .short_delay (cfg_ff.short_delay),
      .status      (nxt_status)
   );

   // A commutation on the next-step channel is what the bad-step count watches.
   esc_cts_supervisor u_supervisor (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .func        (in_item_ff.func),
      .pulse_seen  (in_item_ff.pulse_seen),
      .pulse_width (in_item_ff.pulse_width),
      .next_fire   (nxt_status.fire),
      .cfg         (cfg_ff),
      .status      (sup_status)
   );

   always_comb begin
      out_data_in        = '0;
      out_data_in[0]     = det_status.fire;
      out_data_in[1]     = nxt_status.fire;
      out_data_in[2]     = det_status.armed;
      out_data_in[3]     = nxt_status.armed;
      out_data_in[13:4]  = det_status.compare;
      out_data_in[23:14] = nxt_status.compare;
      out_data_in[33:24] = sup_status.duty;
      out_data_in[34]    = sup_status.duty_write;
      out_data_in[37:35] = sup_status.motor_state;
      out_data_in[38]    = sup_status.beep;
      out_data_in[39]    = sup_status.speed_tick;
      out_data_in[40]    = sup_status.commutation_error;
   end

   // Response register: filled on every processed request, emptied by a response transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the ESC commutation and throttle supervisor.
`timescale 1ns / 100ps

module tb;
   import esc_cts_pkg::*;

   // Spare function codes that the block must treat as no-operation.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = FUNC_START_DONE + 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = FUNC_START_DONE + 3'd2;

   localparam int DETECT_CH = 0;
   localparam int NEXT_CH   = 1;

   localparam int unsigned IDLE_PCT    = 36;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // One response as it sits in rsp_tdata, fields listed from the top bit down so that
   // fire_detect lands in bit 0.
   typedef struct packed {
      logic               commutation_error;
      logic               speed_tick;
      logic               beep;
      logic [STATE_W-1:0] motor_state;
      logic               duty_write;
      logic [CMP_W-1:0]   duty;
      logic [CMP_W-1:0]   next_compare;
      logic [CMP_W-1:0]   detect_compare;
      logic               next_armed;
      logic               detect_armed;
      logic               fire_next;
      logic               fire_detect;
   } sup_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   esc_commutation_and_throttle_supervisor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor state: our own copy of the registers and of the supervisor's internal state.
   // ---------------------------------------------------------------------------------------
   cfg_type            reg_file;
   logic [STATE_W-1:0] motor_mode;
   bit                 signal_lost;
   logic [LOSS_W-1:0]  quiet_ticks;
   logic [BEEP_W-1:0]  beep_ticks;
   logic [SPEED_W-1:0] speed_ticks;
   logic [BAD_W-1:0]   bad_step_count;
   logic [CMP_W-1:0]   duty_level;
   logic [PULSE_W-1:0] throttle_us;
   // Per commutation channel, indexed by DETECT_CH and NEXT_CH.
   bit                 ch_pending [2];
   logic [REM_W-1:0]   ch_remaining [2];
   bit                 ch_enabled [2];
   logic [CMP_W-1:0]   ch_compare [2];

   req_item_type queued_requests [$];
   sup_result_t  awaited_results [$];
   req_item_type held_req;
   sup_result_t  got, want;
   bit           offer_free;
   bit           src_steady = 1'b0;
   logic         sink_hold_kick = 1'b0;
   int unsigned  sink_hold_left;

   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned result_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned settings_used = 1;
   int unsigned detect_fires = 0, next_fires = 0, beep_count_seen = 0;
   int unsigned speed_samples = 0, bad_step_errors = 0;
   logic [7:0]  states_seen = '0;

   // A forced (next-step) commutation counts as a bad step; the counter sticks at full scale.
   function automatic void count_bad_step();
      if (bad_step_count != {BAD_W{1'b1}}) bad_step_count = bad_step_count + 1'b1;
   endfunction

   // A held delay loses one timer period per tick. Once what is left fits in one period plus
   // the short limit it fires; once it fits in one period the compare is armed as well.
   function automatic bit period_countdown(int ch);
      int unsigned left;
      left = ch_remaining[ch];
      if (!ch_pending[ch]) return 1'b0;
      if (left <= TIMER_PERIOD + reg_file.short_delay) begin
         ch_remaining[ch] = (left > TIMER_PERIOD) ? left - TIMER_PERIOD : 0;
         ch_enabled[ch]   = 1'b0;
         ch_pending[ch]   = 1'b0;
         return 1'b1;
      end
      left = left - TIMER_PERIOD;
      ch_remaining[ch] = left[REM_W-1:0];
      if (left <= TIMER_PERIOD) begin
         ch_compare[ch] = left[CMP_W-1:0];
         ch_enabled[ch] = 1'b1;
      end
      return 1'b0;
   endfunction

   // Scheduling: a short delay fires at once, one ending inside this period arms the
   // compare, anything longer is held for the tick countdown.
   function automatic bit arm_delay(int ch, int unsigned delay, int unsigned now);
      int unsigned stop_at;
      stop_at = delay + now;
      if (delay <= reg_file.short_delay) begin
         ch_enabled[ch] = 1'b0;
         return 1'b1;
      end
      if (stop_at <= TIMER_PERIOD) begin
         ch_compare[ch] = stop_at[CMP_W-1:0];
         ch_enabled[ch] = 1'b1;
      end else begin
         ch_enabled[ch]   = 1'b0;
         ch_remaining[ch] = stop_at[REM_W-1:0];
         ch_pending[ch]   = 1'b1;
      end
      return 1'b0;
   endfunction

   // The expected response to one accepted request; advances the predictor's state.
   function automatic sup_result_t supervise_item(req_item_type it);
      sup_result_t r;
      int unsigned level;
      r = '0;
      case (it.func)
         FUNC_SCHED_DETECT: r.fire_detect = arm_delay(DETECT_CH, it.delay_us, it.timer_now);
         FUNC_SCHED_NEXT: begin
            if (arm_delay(NEXT_CH, it.delay_us, it.timer_now)) begin
               r.fire_next = 1'b1;
               count_bad_step();
            end
         end
         FUNC_DETECT_MATCH: begin
            if (ch_enabled[DETECT_CH]) begin
               ch_enabled[DETECT_CH] = 1'b0;
               ch_pending[DETECT_CH] = 1'b0;
               r.fire_detect = 1'b1;
            end
         end
         FUNC_NEXT_MATCH: begin
            if (ch_enabled[NEXT_CH]) begin
               ch_enabled[NEXT_CH] = 1'b0;
               ch_pending[NEXT_CH] = 1'b0;
               r.fire_next = 1'b1;
               count_bad_step();
            end
         end
         FUNC_START_DONE: begin
            if (motor_mode == STATE_START) motor_mode = STATE_RUNNING;
         end
         FUNC_TICK: begin
            if (period_countdown(DETECT_CH)) r.fire_detect = 1'b1;
            if (period_countdown(NEXT_CH)) begin
               r.fire_next = 1'b1;
               count_bad_step();
            end
            // Throttle pulse watch with signal-loss timing.
            if (!it.pulse_seen) begin
               if (!signal_lost && quiet_ticks != {LOSS_W{1'b1}})
                  quiet_ticks = quiet_ticks + 1'b1;
               if (quiet_ticks >= reg_file.signal_loss_ticks) signal_lost = 1'b1;
            end else begin
               signal_lost = 1'b0;
               quiet_ticks = '0;
               throttle_us = it.pulse_width;
            end
            if (!signal_lost) begin
               if (motor_mode == STATE_RUNNING) begin
                  if (throttle_us >= reg_file.throttle_zero) begin
                     level = throttle_us - reg_file.throttle_zero;
                     if (level >= reg_file.duty_max) level = reg_file.duty_max;
                     else if (level <= reg_file.duty_min) level = reg_file.duty_min;
                     duty_level = level[CMP_W-1:0];
                  end else begin
                     motor_mode   = STATE_STOP;
                     duty_level   = '0;
                     r.duty_write = 1'b1;
                  end
               end else if (motor_mode == STATE_STANDBY) begin
                  if (throttle_us >= reg_file.throttle_zero) motor_mode = STATE_START;
               end else if (motor_mode == STATE_STOP || motor_mode == STATE_ERROR) begin
                  if (throttle_us < reg_file.throttle_zero) motor_mode = STATE_STANDBY;
                  beep_ticks = beep_ticks + 1'b1;
                  if (beep_ticks == reg_file.beep_period) begin
                     r.beep     = 1'b1;
                     beep_ticks = '0;
                  end
               end
            end else begin
               if (motor_mode != STATE_STOP) begin
                  motor_mode   = STATE_STOP;
                  duty_level   = '0;
                  r.duty_write = 1'b1;
               end else begin
                  beep_ticks = beep_ticks + 1'b1;
               end
               if (beep_ticks == reg_file.beep_period) begin
                  r.beep     = 1'b1;
                  beep_ticks = '0;
               end
            end
            if (motor_mode == STATE_RUNNING || motor_mode == STATE_START) begin
               speed_ticks = speed_ticks + 1'b1;
               if (speed_ticks == reg_file.speed_tick_period) begin
                  r.speed_tick = 1'b1;
                  speed_ticks  = '0;
               end
               if (bad_step_count >= reg_file.bad_step_limit) begin
                  motor_mode          = STATE_ERROR;
                  r.commutation_error = 1'b1;
                  duty_level          = '0;
                  r.duty_write        = 1'b1;
                  bad_step_count      = '0;
               end
            end
            if (motor_mode == STATE_RUNNING || motor_mode == STATE_START) r.duty_write = 1'b1;
         end
         default: ;
      endcase
      r.detect_armed   = ch_enabled[DETECT_CH];
      r.next_armed     = ch_enabled[NEXT_CH];
      r.detect_compare = ch_compare[DETECT_CH];
      r.next_compare   = ch_compare[NEXT_CH];
      r.duty           = duty_level;
      r.motor_state    = motor_mode;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver. Once tvalid is raised it stays up with the same data until the transfer
   // happens; a new item is only loaded when the previous one has gone or none was offered.
   // The expectation is computed at the very edge of the transfer, so it always sees the
   // state left by the previous accepted request.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid     <= 1'b0;
         reg_file.signal_loss_ticks = 10'd500;
         reg_file.beep_period       = 16'd4000;
         reg_file.bad_step_limit    = 8'd50;
         reg_file.throttle_zero     = 14'd1000;
         reg_file.duty_max          = 10'd999;
         reg_file.duty_min          = 10'd5;
         reg_file.speed_tick_period = 8'd10;
         reg_file.short_delay       = 10'd20;
         motor_mode     = STATE_STANDBY;
         signal_lost    = 1'b1;
         quiet_ticks    = '0;
         beep_ticks     = '0;
         speed_ticks    = '0;
         bad_step_count = '0;
         duty_level     = '0;
         throttle_us    = '0;
         for (int ch = 0; ch < 2; ch++) begin
            ch_pending[ch]   = 1'b0;
            ch_remaining[ch] = '0;
            ch_enabled[ch]   = 1'b0;
            ch_compare[ch]   = '0;
         end
      end else begin
         offer_free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(supervise_item(held_req));
            accepted_count++;
            offer_free = 1'b1;
         end
         if (offer_free) begin
            if (queued_requests.size() != 0 &&
                (src_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               held_req   = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, held_req.pulse_width, held_req.pulse_seen,
                              held_req.timer_now, held_req.delay_us};
               req_tuser  <= held_req.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The long receiver hold-off is counted here, apart from the random back-pressure.
   always @(posedge clock) begin
      if (reset) sink_hold_left <= 0;
      else if (sink_hold_kick) sink_hold_left <= HOLD_CYCLES;
      else if (sink_hold_left != 0) sink_hold_left <= sink_hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (sink_hold_left == 0) &&
                         (src_steady || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------------------------
   // Response monitor: every transfer is checked field by field against the oldest
   // expectation.
   // ---------------------------------------------------------------------------------------
   task automatic check_field(string name, int unsigned expected_val, int unsigned actual_val);
      if (expected_val != actual_val) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in response %0d, %s: expected %0d, got %0d",
                     result_count, name, expected_val, actual_val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(sup_result_t)-1:0];
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response %0d arrived with nothing outstanding: %h",
                        result_count, rsp_tdata);
         end else begin
            want = awaited_results.pop_front();
            check_field("fire_detect", want.fire_detect, got.fire_detect);
            check_field("fire_next", want.fire_next, got.fire_next);
            check_field("detect_armed", want.detect_armed, got.detect_armed);
            check_field("next_armed", want.next_armed, got.next_armed);
            check_field("detect_compare", want.detect_compare, got.detect_compare);
            check_field("next_compare", want.next_compare, got.next_compare);
            check_field("duty", want.duty, got.duty);
            check_field("duty_write", want.duty_write, got.duty_write);
            check_field("motor_state", want.motor_state, got.motor_state);
            check_field("beep", want.beep, got.beep);
            check_field("speed_tick", want.speed_tick, got.speed_tick);
            check_field("commutation_error", want.commutation_error, got.commutation_error);
         end
         detect_fires    += got.fire_detect;
         next_fires      += got.fire_next;
         beep_count_seen += got.beep;
         speed_samples   += got.speed_tick;
         bad_step_errors += got.commutation_error;
         states_seen[got.motor_state] = 1'b1;
         result_count++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------------------
   function automatic req_item_type req_of(logic [FUNC_W-1:0] func, int unsigned delay,
                                           int unsigned now, bit seen, int unsigned width);
      req_item_type it;
      it.func        = func;
      it.delay_us    = delay;
      it.timer_now   = now;
      it.pulse_seen  = seen;
      it.pulse_width = width;
      return it;
   endfunction

   // Half the items are ticks carrying a plausible throttle pulse; schedules and matches are
   // mixed in so that the motor gets through start into running and the channels see every
   // path. The fields that an item does not use still carry random values.
   function automatic req_item_type random_item(int unsigned loss_pct);
      req_item_type it;
      int unsigned  pick, shape, width, room;
      it.delay_us    = $urandom_range(0, (1 << DELAY_W) - 1);
      it.timer_now   = $urandom_range(0, (1 << CMP_W) - 1);
      it.pulse_seen  = $urandom_range(0, 1);
      it.pulse_width = $urandom_range(0, (1 << PULSE_W) - 1);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         it.func       = FUNC_TICK;
         it.pulse_seen = ($urandom_range(0, 99) >= loss_pct);
         shape = $urandom_range(0, 99);
         if (shape < 75) width = reg_file.throttle_zero + $urandom_range(0, 1300);
         else if (shape < 92) width = $urandom_range(0, reg_file.throttle_zero);
         else width = $urandom_range(0, (1 << PULSE_W) - 1);
         if (width >= (1 << PULSE_W)) width = (1 << PULSE_W) - 1;
         it.pulse_width = width;
      end else if (pick < 74) begin
         it.func = (pick < 62) ? FUNC_SCHED_DETECT : FUNC_SCHED_NEXT;
         it.timer_now = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << CMP_W) - 1)
                                                     : $urandom_range(0, TIMER_PERIOD);
         room  = (TIMER_PERIOD > it.timer_now) ? TIMER_PERIOD - it.timer_now : 0;
         shape = $urandom_range(0, 99);
         if (shape < 25) it.delay_us = $urandom_range(0, reg_file.short_delay + 3);
         else if (shape < 60) it.delay_us = $urandom_range(reg_file.short_delay + 1, room);
         else if (shape < 90) it.delay_us = $urandom_range(1000, 6000);
         else it.delay_us = $urandom_range(0, (1 << DELAY_W) - 1);
      end else if (pick < 83) begin
         it.func = FUNC_DETECT_MATCH;
      end else if (pick < 92) begin
         it.func = FUNC_NEXT_MATCH;
      end else if (pick < 97) begin
         it.func = FUNC_START_DONE;
      end else begin
         it.func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
      end
      return it;
   endfunction

   task automatic queue_random(int unsigned count, int unsigned loss_pct);
      @(negedge clock);
      repeat (count) queued_requests.push_back(random_item(loss_pct));
      queued_count += count;
   endtask

   // Wait until every queued request has been taken and answered, then leave the block a few
   // cycles to settle; this is also the point where register writes are safe.
   task automatic drain_results();
      while (accepted_count != queued_count || awaited_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SIGNAL_LOSS: reg_file.signal_loss_ticks = value;
         CSR_BEEP_PERIOD: reg_file.beep_period       = value;
         CSR_BAD_LIMIT:   reg_file.bad_step_limit    = value;
         CSR_THR_ZERO:    reg_file.throttle_zero     = value;
         CSR_DUTY_MAX:    reg_file.duty_max          = value;
         CSR_DUTY_MIN:    reg_file.duty_min          = value;
         CSR_SPEED_TICK:  reg_file.speed_tick_period = value;
         CSR_SHORT_DELAY: reg_file.short_delay       = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(int unsigned loss, int unsigned beep_gap, int unsigned bad_lim,
                                int unsigned zero_us, int unsigned dmax, int unsigned dmin,
                                int unsigned speed_gap, int unsigned short_us);
      write_reg(CSR_SIGNAL_LOSS, loss);
      write_reg(CSR_BEEP_PERIOD, beep_gap);
      write_reg(CSR_BAD_LIMIT, bad_lim);
      write_reg(CSR_THR_ZERO, zero_us);
      write_reg(CSR_DUTY_MAX, dmax);
      write_reg(CSR_DUTY_MIN, dmin);
      write_reg(CSR_SPEED_TICK, speed_gap);
      write_reg(CSR_SHORT_DELAY, short_us);
      settings_used++;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset settings: spin the motor up, hit both duty clamps, take
      // scheduling paths (immediate and armed on the detect channel; held then armed and held
      // then fired without a match on both), stray matches, spare codes, a late start-done, a
      // lost pulse and last a throttle drop that stops the motor and returns it to standby.
      @(negedge clock);
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 1500));
      queued_requests.push_back(req_of(FUNC_START_DONE, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 1500));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, (1 << PULSE_W) - 1));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 1002));
      queued_requests.push_back(req_of(FUNC_SCHED_DETECT, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_SCHED_DETECT, 20, 500, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_SCHED_DETECT, 21, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_DETECT_MATCH, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_DETECT_MATCH, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_NEXT_MATCH, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_SCHED_NEXT, 100, 900, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 1500));
      queued_requests.push_back(req_of(FUNC_SCHED_NEXT, 1500, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 1500));
      queued_requests.push_back(req_of(FUNC_NEXT_MATCH, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_SCHED_DETECT, 1500, 200, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 1500));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 1500));
      queued_requests.push_back(req_of(FUNC_SPARE_A, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_SPARE_B, (1 << DELAY_W) - 1, (1 << CMP_W) - 1,
                                       1'b1, (1 << PULSE_W) - 1));
      queued_requests.push_back(req_of(FUNC_SCHED_NEXT, (1 << DELAY_W) - 1, (1 << CMP_W) - 1,
                                       1'b1, (1 << PULSE_W) - 1));
      queued_requests.push_back(req_of(FUNC_START_DONE, 0, 0, 1'b0, 0));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b0, (1 << PULSE_W) - 1));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 0));
      queued_requests.push_back(req_of(FUNC_TICK, 0, 0, 1'b1, 0));
      queued_count += 26;
      drain_results();

      // Reset settings, no idling on either side. Once the request queue is full the
      // receiver holds off for a long stretch, so the block's registers fill and the request
      // side has to stall.
      src_steady = 1'b1;
      queue_random(180, 2);
      @(posedge clock);
      sink_hold_kick <= 1'b1;
      @(posedge clock);
      sink_hold_kick <= 1'b0;
      drain_results();
      src_steady = 1'b0;

      // Short timings: the signal is lost after a few quiet ticks, beeps come quickly and a
      // handful of forced steps trips the bad-step error.
      load_settings(3, 2, 3, 1000, 600, 100, 1, 0);
      queue_random(180, 15);
      drain_results();

      // Upper extremes of every register but throttle zero; duty clamps at full scale.
      load_settings((1 << LOSS_W) - 1, (1 << BEEP_W) - 1, (1 << BAD_W) - 1, 10000,
                    (1 << CMP_W) - 1, (1 << CMP_W) - 1, (1 << SPEED_W) - 1, (1 << CMP_W) - 1);
      queue_random(150, 5);
      drain_results();

      // Lower extremes.
      load_settings(1, 1, 1, 0, 0, 0, 1, 0);
      queue_random(150, 20);
      drain_results();

      // Random mid-range settings.
      load_settings($urandom_range(1, 40), $urandom_range(1, 50), $urandom_range(1, 20),
                    $urandom_range(0, 10000), $urandom_range(0, 999), $urandom_range(0, 999),
                    $urandom_range(1, 255), $urandom_range(0, 999));
      queue_random(240, 8);
      drain_results();

      repeat (8) @(posedge clock);
      $display("summary: %0d requests over %0d register settings; %0d detect and %0d forced",
               accepted_count, settings_used, detect_fires, next_fires);
      $display("summary: steps, %0d beeps, %0d speed samples, %0d bad-step errors, states %b",
               beep_count_seen, speed_samples, bad_step_errors, states_seen[4:0]);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/esc_cts_pkg.sv
rtl/esc_cts_channel.sv
rtl/esc_cts_supervisor.sv
rtl/esc_commutation_and_throttle_supervisor.sv
tb/tb.sv
